// ----- src/tbbu_pkg.sv -----
// Package for the two-bit branch predictor with BTB: sizes, item types and
// small helper functions. It depends on nothing else.
package tbbu_pkg;

    localparam int PRED_ENTRIES = 1024;
    localparam int BTB_ENTRIES  = 256;

    localparam int PRED_IDX_W = $clog2(PRED_ENTRIES);
    localparam int BTB_IDX_W  = $clog2(BTB_ENTRIES);
    localparam int PC_W       = 32;
    localparam int TAG_W      = PC_W - PRED_IDX_W;
    localparam int CNT_W      = 2;
    localparam int TOTAL_W    = 32;

    typedef logic [PRED_IDX_W-1:0] t_pidx;
    typedef logic [BTB_IDX_W-1:0]  t_bidx;
    typedef logic [TAG_W-1:0]      t_tag;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [TOTAL_W-1:0]    t_total;

    // Branch kinds and counter values.
    localparam logic [1:0] KIND_COND = 2'd1;
    localparam t_cnt       CNT_MIN   = 2'd0;
    localparam t_cnt       CNT_INIT  = 2'd1;
    localparam t_cnt       CNT_MAX   = 2'd3;
    localparam t_total     TOTAL_MAX = '1;

    typedef struct packed {
        logic [PC_W-1:0] pc_address;
        logic [1:0]      branch_kind;
        logic            taken;
    } t_in_item;

    typedef struct packed {
        logic   predicted_taken;
        logic   mispredicted;
        logic   btb_checked;
        logic   btb_hit;
        t_cnt   old_counter;
        t_cnt   new_counter;
        t_total branches_seen;
        t_total mispredictions_seen;
        t_total predicted_taken_seen;
        t_total btb_misses_seen;
    } t_out_item;

    // Events of one committing branch, for the statistics block.
    typedef struct packed {
        logic commit;
        logic pred;
        logic miss;
        logic btb_miss;
    } t_stat_evt;

    typedef struct packed {
        t_total branches;
        t_total mispredicts;
        t_total pred_taken;
        t_total btb_misses;
    } t_totals;

    function automatic t_pidx pred_idx(input logic [PC_W-1:0] pc);
        return pc[PRED_IDX_W+1:2];
    endfunction

    function automatic t_bidx btb_idx(input logic [PC_W-1:0] pc);
        return pc[BTB_IDX_W+1:2];
    endfunction

    function automatic t_tag pc_tag(input logic [PC_W-1:0] pc);
        return pc[PC_W-1:PRED_IDX_W];
    endfunction

    function automatic t_cnt cnt_next(input t_cnt old, input logic tk);
        t_cnt res;
        if (tk) begin
            res = (old == CNT_MAX) ? CNT_MAX : old + t_cnt'(1);
        end else begin
            res = (old == CNT_MIN) ? CNT_MIN : old - t_cnt'(1);
        end
        return res;
    endfunction

    function automatic t_total sat_inc(input t_total v, input logic en);
        t_total res;
        res = v;
        if (en && (v != TOTAL_MAX)) begin
            res = v + t_total'(1);
        end
        return res;
    endfunction

endpackage

// ----- src/tbbu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; a read at the address being written returns the old data.
module tbbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tbbu_stats.sv -----
// Saturating running totals of the predictor.
// Depends on tbbu_pkg for the event and totals types.
module tbbu_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbbu_pkg::t_stat_evt i_evt,
    output tbbu_pkg::t_totals  o_totals
);

    tbbu_pkg::t_totals r_totals;
    tbbu_pkg::t_totals n_totals;

    // The totals including the events of the branch now committing.
    always_comb begin
        n_totals.branches    = tbbu_pkg::sat_inc(r_totals.branches, 1'b1);
        n_totals.mispredicts = tbbu_pkg::sat_inc(r_totals.mispredicts, i_evt.miss);
        n_totals.pred_taken  = tbbu_pkg::sat_inc(r_totals.pred_taken, i_evt.pred);
        n_totals.btb_misses  = tbbu_pkg::sat_inc(r_totals.btb_misses, i_evt.btb_miss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_totals <= '0;
        end else if (i_evt.commit) begin
            r_totals <= n_totals;
        end
    end

    assign o_totals = n_totals;

endmodule

// ----- src/two_bit_predictor_with_btb_unit.sv -----
// Top level of the bimodal two-bit branch predictor with a direct-mapped BTB.
// Depends on tbbu_pkg, tbbu_ram and tbbu_stats.

// Each input item is one resolved branch. Items whose kind is not the
// conditional kind are taken in and dropped without a result or any change
// of state. A conditional branch gives one result item, which is registered
// in stage 1 and then in the result register before it is presented on the
// result port. The block takes one item in every cycle as long as the result
// side keeps up. The rate is set by the counter table, a RAM with one
// registered read port and one write port: the counter is read when the item
// is accepted and written back when the item leaves stage 1, and a branch
// that follows straight behind another on the same counter (or the same BTB
// entry) gets the freshly written value by forwarding. After reset the block
// walks through the counter table once, writing the weakly-not-taken value
// into every entry; o_in_stall is held high while this pass runs. The BTB
// valid bits are flip-flops cleared by reset, so the tag RAM needs no
// clearing. The running totals in every result include the branch that
// result belongs to and stop at their maximum value rather than wrapping.
module two_bit_predictor_with_btb_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tbbu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tbbu_pkg::t_out_item o_out_item
);

    // Stage 1 holds one accepted conditional branch together with whatever
    // was forwarded from the branch ahead of it.
    typedef struct packed {
        logic [tbbu_pkg::PC_W-1:0] pc_address;
        logic                      taken;
        logic                      fwd_cnt_hit;
        tbbu_pkg::t_cnt            fwd_cnt;
        logic                      fwd_tag_hit;
        tbbu_pkg::t_tag            fwd_tag;
    } t_s1;

    logic               r_clr_busy;
    tbbu_pkg::t_pidx    r_clr_idx;

    logic               r_s1_valid;
    t_s1                r_s1;
    logic               r_out_valid;
    tbbu_pkg::t_out_item r_out;

    logic [tbbu_pkg::BTB_ENTRIES-1:0] r_btb_valid;

    logic               accept;
    logic               s1_advance;
    logic               s1_commit;

    tbbu_pkg::t_pidx    in_pidx;
    tbbu_pkg::t_bidx    in_bidx;
    tbbu_pkg::t_pidx    s1_pidx;
    tbbu_pkg::t_bidx    s1_bidx;
    tbbu_pkg::t_tag     s1_tag;

    tbbu_pkg::t_cnt     cnt_rdata;
    tbbu_pkg::t_tag     tag_rdata;
    tbbu_pkg::t_cnt     old_cnt;
    tbbu_pkg::t_cnt     new_cnt;
    tbbu_pkg::t_tag     stored_tag;
    logic               pred;
    logic               miss;
    logic               hit;

    logic               cnt_we;
    tbbu_pkg::t_pidx    cnt_waddr;
    tbbu_pkg::t_cnt     cnt_wdata;

    tbbu_pkg::t_stat_evt evt;
    tbbu_pkg::t_totals   totals;
    t_s1                 n_s1;

    // Handshake. Stage 1 moves on whenever the result register is empty or
    // being emptied, so a waiting result does not stop a new item entering
    // stage 1 when that stage is free.
    assign s1_advance = !r_out_valid || !i_out_stall;
    assign s1_commit  = r_s1_valid && s1_advance;
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_advance);
    assign accept     = i_in_valid && !o_in_stall;

    assign in_pidx = tbbu_pkg::pred_idx(i_in_item.pc_address);
    assign in_bidx = tbbu_pkg::btb_idx(i_in_item.pc_address);
    assign s1_pidx = tbbu_pkg::pred_idx(r_s1.pc_address);
    assign s1_bidx = tbbu_pkg::btb_idx(r_s1.pc_address);
    assign s1_tag  = tbbu_pkg::pc_tag(r_s1.pc_address);

    // The counter write port is shared between the clearing pass after reset
    // and the write-back of the committing branch; the two never overlap,
    // because no item is accepted while the pass runs.
    always_comb begin
        cnt_we    = r_clr_busy || s1_commit;
        cnt_waddr = r_clr_busy ? r_clr_idx : s1_pidx;
        cnt_wdata = r_clr_busy ? tbbu_pkg::CNT_INIT : new_cnt;
    end

    tbbu_ram #(
        .WIDTH (tbbu_pkg::CNT_W),
        .DEPTH (tbbu_pkg::PRED_ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (accept),
        .i_raddr (in_pidx),
        .o_rdata (cnt_rdata)
    );

    // Tags are written only by taken branches and read only behind a set
    // valid bit, so the RAM contents before the first write never matter.
    tbbu_ram #(
        .WIDTH (tbbu_pkg::TAG_W),
        .DEPTH (tbbu_pkg::BTB_ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (s1_commit && r_s1.taken),
        .i_waddr (s1_bidx),
        .i_wdata (s1_tag),
        .i_re    (accept),
        .i_raddr (in_bidx),
        .o_rdata (tag_rdata)
    );

    // Prediction, BTB lookup and counter update for the branch in stage 1.
    // The valid bits are read here, after the RAM read has been registered, so they
    // already include the write of the branch just ahead.
    always_comb begin
        old_cnt    = r_s1.fwd_cnt_hit ? r_s1.fwd_cnt : cnt_rdata;
        stored_tag = r_s1.fwd_tag_hit ? r_s1.fwd_tag : tag_rdata;
        pred       = old_cnt[1];
        hit        = pred && r_btb_valid[s1_bidx] && (stored_tag == s1_tag);
        miss       = pred != r_s1.taken;
        new_cnt    = tbbu_pkg::cnt_next(old_cnt, r_s1.taken);
    end

    always_comb begin
        evt.commit   = s1_commit;
        evt.pred     = pred;
        evt.miss     = miss;
        evt.btb_miss = pred && !hit;
    end

    tbbu_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt),
        .o_totals (totals)
    );

    // What stage 1 captures on accept. When the branch now committing writes
    // the very entry that is being read, the RAM returns the old value, so the
    // new one is carried along and used instead.
    always_comb begin
        n_s1.pc_address  = i_in_item.pc_address;
        n_s1.taken       = i_in_item.taken;
        n_s1.fwd_cnt_hit = s1_commit && (s1_pidx == in_pidx);
        n_s1.fwd_cnt     = new_cnt;
        n_s1.fwd_tag_hit = s1_commit && r_s1.taken && (s1_bidx == in_bidx);
        n_s1.fwd_tag     = s1_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_btb_valid <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + tbbu_pkg::t_pidx'(1);
                if (r_clr_idx == tbbu_pkg::t_pidx'(tbbu_pkg::PRED_ENTRIES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (!o_in_stall) begin
                r_s1_valid <= accept && (i_in_item.branch_kind == tbbu_pkg::KIND_COND);
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_commit && r_s1.taken) begin
                r_btb_valid[s1_bidx] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_commit) begin
            r_out.predicted_taken      <= pred;
            r_out.mispredicted         <= miss;
            r_out.btb_checked          <= pred;
            r_out.btb_hit              <= hit;
            r_out.old_counter          <= old_cnt;
            r_out.new_counter          <= new_cnt;
            r_out.branches_seen        <= totals.branches;
            r_out.mispredictions_seen  <= totals.mispredicts;
            r_out.predicted_taken_seen <= totals.pred_taken;
            r_out.btb_misses_seen      <= totals.btb_misses;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- src/tbbu_checker.sv -----
// Port-level checks for the two-bit predictor with BTB, bound to the top level.
// Depends on tbbu_pkg for the item types.
module tbbu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input tbbu_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tbbu_pkg::t_out_item o_out_item
);

    // Reset empties the pipeline and starts the clearing pass.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_stall))
        else $error("pipeline not empty or input open after reset");

    // A stalled input item stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("stalled input item changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // The prediction, the lookup flag and a hit all follow from the old counter.
    a_pred_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.predicted_taken == o_out_item.old_counter[1])
                         && (o_out_item.btb_checked == o_out_item.predicted_taken)
                         && (o_out_item.btb_hit ? o_out_item.btb_checked : 1'b1)))
        else $error("prediction fields disagree");

    a_totals_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.mispredictions_seen <= o_out_item.branches_seen)
                         && (o_out_item.predicted_taken_seen <= o_out_item.branches_seen)
                         && (o_out_item.btb_misses_seen <= o_out_item.predicted_taken_seen)))
        else $error("running totals out of order");

endmodule

bind two_bit_predictor_with_btb_unit tbbu_checker u_tbbu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
